// File: rtl/jsu_pkg.sv
// Shared types, status codes and helper functions for the JSON string unescaper.
package jsu_pkg;

    // Result status codes.
    localparam logic [2:0] ST_DATA    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_NOQUOTE = 3'd2;
    localparam logic [2:0] ST_UNTERM  = 3'd3;
    localparam logic [2:0] ST_BADU    = 3'd4;
    localparam logic [2:0] ST_BADESC  = 3'd5;

    localparam int MAX_BEATS = 4;

    // One group of result beats caused by a single input request.
    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [2:0]                status;
        logic [2:0]                count;
    } jsu_group_t;

    // Value of an ASCII hex digit; bit 4 set marks a non-hex character.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // Encode a code point as one to four UTF-8 data bytes.
    function automatic jsu_group_t encode_utf8(input logic [20:0] cp);
        jsu_group_t g;
        g.bytes  = '0;
        g.status = ST_DATA;
        if (cp <= 21'h7F) begin
            g.bytes[0] = {1'b0, cp[6:0]};
            g.count    = 3'd1;
        end else if (cp <= 21'h7FF) begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.count    = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.count    = 3'd3;
        end else begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.count    = 3'd4;
        end
        return g;
    endfunction

    // A single beat that carries a data byte.
    function automatic jsu_group_t one_byte(input logic [7:0] b);
        jsu_group_t g;
        g.bytes    = '0;
        g.bytes[0] = b;
        g.status   = ST_DATA;
        g.count    = 3'd1;
        return g;
    endfunction

    // A single status beat with a zero byte.
    function automatic jsu_group_t one_status(input logic [2:0] st);
        jsu_group_t g;
        g.bytes  = '0;
        g.status = st;
        g.count  = 3'd1;
        return g;
    endfunction

endpackage

// File: rtl/jsu_decode.sv
// Escape decoder: parse state registers and the per-request decode logic.
module jsu_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               strict_mode,
    input  logic               in_fire,
    input  logic [7:0]         in_byte,
    input  logic               end_of_input,
    output jsu_pkg::jsu_group_t grp
);
    import jsu_pkg::*;

    localparam logic [3:0] PH_QUOTE   = 4'd0;
    localparam logic [3:0] PH_BODY    = 4'd1;
    localparam logic [3:0] PH_ESC     = 4'd2;
    localparam logic [3:0] PH_HEX1    = 4'd3;
    localparam logic [3:0] PH_WANT_BS = 4'd4;
    localparam logic [3:0] PH_WANT_U  = 4'd5;
    localparam logic [3:0] PH_HEX2    = 4'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic [9:0]  hs_reg, hs_next;

    logic [4:0]  hv;
    logic [15:0] acc_shift;
    logic [20:0] pair_cp;

    assign hv        = end_of_input ? 5'h10 : hex_value(in_byte);
    assign acc_shift = {acc_reg[11:0], hv[3:0]};
    assign pair_cp   = 21'h10000 + {1'b0, hs_reg, acc_shift[9:0]};

    // Next state and result group for the current request.
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        hs_next    = hs_reg;
        grp        = '0;
        unique case (phase_reg)
            PH_QUOTE: begin
                if (end_of_input || in_byte != CH_QUOTE) begin
                    grp = one_status(ST_NOQUOTE);
                end else begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY: begin
                if (end_of_input) begin
                    grp = one_status(ST_UNTERM);
                    phase_next = PH_QUOTE;
                end else if (in_byte == CH_QUOTE) begin
                    grp = one_status(ST_DONE);
                    phase_next = PH_QUOTE;
                end else if (in_byte == CH_BSL) begin
                    phase_next = PH_ESC;
                end else begin
                    grp = one_byte(in_byte);
                end
            end
            PH_ESC: begin
                phase_next = PH_BODY;
                if (end_of_input) begin
                    grp = one_status(ST_UNTERM);
                    phase_next = PH_QUOTE;
                end else begin
                    case (in_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: grp = one_byte(in_byte);
                        CH_B: grp = one_byte(8'h08);
                        CH_F: grp = one_byte(8'h0C);
                        CH_N: grp = one_byte(8'h0A);
                        CH_R: grp = one_byte(8'h0D);
                        CH_T: grp = one_byte(8'h09);
                        CH_U: begin
                            phase_next = PH_HEX1;
                            acc_next   = '0;
                            dcnt_next  = '0;
                        end
                        default: begin
                            if (strict_mode) begin
                                grp = one_status(ST_BADESC);
                                phase_next = PH_QUOTE;
                            end else begin
                                grp.bytes[0] = CH_BSL;
                                grp.bytes[1] = in_byte;
                                grp.status   = ST_DATA;
                                grp.count    = 3'd2;
                            end
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (hv[4]) begin
                    grp = one_status(ST_BADU);
                    phase_next = PH_QUOTE;
                end else begin
                    acc_next = acc_shift;
                    if (dcnt_reg != 2'd3) begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end else begin
                        dcnt_next = '0;
                        if (phase_reg == PH_HEX1) begin
                            if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
                                hs_next    = acc_shift[9:0];
                                phase_next = PH_WANT_BS;
                            end else begin
                                phase_next = PH_BODY;
                                grp        = encode_utf8({5'd0, acc_shift});
                            end
                        end else if (acc_shift < 16'hDC00 || acc_shift > 16'hDFFF) begin
                            grp = one_status(ST_BADU);
                            phase_next = PH_QUOTE;
                        end else begin
                            phase_next = PH_BODY;
                            hs_next    = '0;
                            grp        = encode_utf8(pair_cp);
                        end
                    end
                end
            end
            PH_WANT_BS: begin
                if (end_of_input || in_byte != CH_BSL) begin
                    grp = one_status(ST_BADU);
                    phase_next = PH_QUOTE;
                end else begin
                    phase_next = PH_WANT_U;
                end
            end
            PH_WANT_U: begin
                if (end_of_input || in_byte != CH_U) begin
                    grp = one_status(ST_BADU);
                    phase_next = PH_QUOTE;
                end else begin
                    phase_next = PH_HEX2;
                    acc_next   = '0;
                    dcnt_next  = '0;
                end
            end
            default: begin
                grp = one_status(ST_NOQUOTE);
                phase_next = PH_QUOTE;
            end
        endcase
        // Any error clears the escape state.
        if (grp.count != 3'd0 && grp.status != ST_DATA && grp.status != ST_DONE) begin
            acc_next  = '0;
            dcnt_next = '0;
            hs_next   = '0;
        end
    end

    // State advances only on an accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_QUOTE;
            acc_reg   <= '0;
            dcnt_reg  <= '0;
            hs_reg    <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            dcnt_reg  <= dcnt_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

// File: rtl/jsu_outbuf.sv
// Result register that holds one group of beats and sends them out one per cycle while m_tready is high.
module jsu_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  jsu_pkg::jsu_group_t grp,
    output logic               can_load,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [2:0]         m_tuser
);
    import jsu_pkg::*;

    logic [MAX_BEATS-1:0][7:0] bytes_reg;
    logic [2:0]                status_reg;
    logic [2:0]                left_reg;
    logic [1:0]                idx_reg;
    logic                      take;

    assign m_tvalid = (left_reg != 3'd0);
    assign take     = m_tvalid && m_tready;
    assign can_load = (left_reg == 3'd0) || (take && left_reg == 3'd1);
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tlast  = (left_reg == 3'd1);
    assign m_tuser  = status_reg;

    // Beat counter; a new group loads into an empty register or replaces the one whose last beat just left.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            idx_reg  <= '0;
        end else if (load) begin
            left_reg <= grp.count;
            idx_reg  <= '0;
        end else if (take) begin
            left_reg <= left_reg - 3'd1;
            idx_reg  <= idx_reg + 2'd1;
        end
    end

    // Payload of the held group.
    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg  <= grp.bytes;
            status_reg <= grp.status;
        end
    end

endmodule

// File: rtl/json_string_unescape_to_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input stream: one source byte per request in s_tdata, s_tuser marks end of
// input (no byte carried). Output stream: one UTF-8 byte or status per beat,
// m_tuser is the status (0 data, 1 done, 2 no opening quote, 3 unterminated,
// 4 bad unicode escape, 5 invalid escape), m_tlast marks the final beat that a
// request causes. Status beats carry a zero byte.
// The beats of a request appear on the cycle after it is accepted. A request
// that yields zero or one beat does not hold back the next, so plain text flows
// at one byte per cycle while m_tready is high. A request that yields N beats
// (up to four, from a \u escape or a passed-through unknown escape) holds
// s_tready low until its last beat leaves, as there is one result register.
// Opening quotes, backslashes and leading hex digits yield no beat.
// When the receiver stalls, the held beat stays on m_tdata and new requests
// wait once the result register is full.
// Reset (aresetn low, synchronous) empties the output, returns the parser to
// waiting for an opening quote and sets strict_mode to 1. The user must use
// cfg_wr_en to write strict_mode while the block is idle; nothing enforces it.
module json_string_unescape_to_utf8_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,  // strict_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_byte
    input  logic       s_tuser,      // [0] end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast,
    output logic [2:0] m_tuser       // [2:0] status
);
    import jsu_pkg::*;

    logic       strict_reg;
    logic       in_fire;
    logic       can_load;
    jsu_group_t grp;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            strict_reg <= cfg_wr_data;
        end
    end

    assign s_tready = can_load;
    assign in_fire  = s_tvalid && s_tready;

    jsu_decode u_decode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .strict_mode  (strict_reg),
        .in_fire      (in_fire),
        .in_byte      (s_tdata),
        .end_of_input (s_tuser),
        .grp          (grp)
    );

    jsu_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (in_fire && grp.count != 3'd0),
        .grp      (grp),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An empty result register always takes a request.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output is empty");

    // Status beats stand alone with a zero byte.
    a_status_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_DATA) |-> (m_tlast && m_tdata == 8'd0))
        else $error("status beat is not a single zero beat");

    // Reset leaves the output empty.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
